// ----- hw/rtl/bbpm_pkg.sv -----
// ----------------------------------------------------------------------------
// bbpm_pkg
// Shared widths, types and constants for the bone matrix pipeline.
// ----------------------------------------------------------------------------
package bbpm_pkg;

  localparam int CoordW = 24;
  localparam int MatW   = 32;
  localparam int DiffW  = 25;
  localparam int SqW    = 52;  // dx*dx + dy*dy
  localparam int RadW   = 66;  // l2 << 14
  localparam int LenW   = 33;  // isqrt result
  localparam int NumW   = 49;  // d * 2^23
  localparam int TrigW  = 18;  // |c|,|s| <= 65536, signed

  localparam logic [MatW-1:0] One = 32'sd65536;

  typedef enum logic {
    OP_BIND = 1'b0,
    OP_POSE = 1'b1
  } op_t;

  typedef struct packed {
    logic [MatW-1:0] m00;
    logic [MatW-1:0] m01;
    logic [MatW-1:0] m02;
    logic [MatW-1:0] m10;
    logic [MatW-1:0] m11;
    logic [MatW-1:0] m12;
  } mat_t;

  // Floor shift of a wide signed value followed by 32-bit saturation.
  function automatic logic [MatW-1:0] fsat(input logic signed [71:0] v, input int n);
    logic signed [71:0] q;
    begin
      q = v >>> n;
      if (q > 72'sd2147483647) fsat = 32'h7fffffff;
      else if (q < -72'sd2147483648) fsat = 32'h80000000;
      else fsat = q[MatW-1:0];
    end
  endfunction

endpackage

// ----- hw/rtl/bbpm_if.sv -----
// ----------------------------------------------------------------------------
// bbpm_in_if / bbpm_out_if
// Valid/ready channels for bone items and matrix results.
// ----------------------------------------------------------------------------
interface bbpm_in_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [4:0]                bone;
  logic signed [23:0]        start_x;
  logic signed [23:0]        start_y;
  logic signed [23:0]        end_x;
  logic signed [23:0]        end_y;
  modport source (output valid, operation, bone, start_x, start_y, end_x, end_y,
                  input ready);
  modport sink (input valid, operation, bone, start_x, start_y, end_x, end_y,
                output ready);
endinterface

interface bbpm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] m00;
  logic signed [31:0] m01;
  logic signed [31:0] m02;
  logic signed [31:0] m10;
  logic signed [31:0] m11;
  logic signed [31:0] m12;
  logic               zero_length;
  modport source (output valid, m00, m01, m02, m10, m11, m12, zero_length,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, zero_length,
                output ready);
endinterface

// ----- hw/rtl/bbpm_sqrt.sv -----
// ----------------------------------------------------------------------------
// bbpm_sqrt
// Pipelined integer square root, two result bits per stage, with sideband.
// ----------------------------------------------------------------------------
module bbpm_sqrt #(
  parameter int SideW = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [bbpm_pkg::RadW-1:0]   x,
  input  logic [SideW-1:0]            in_side,
  output logic                        out_valid,
  output logic [bbpm_pkg::LenW-1:0]   root,
  output logic [SideW-1:0]            out_side
);
  import bbpm_pkg::*;

  localparam int Bits   = 34;   // root bits for a 68-bit radicand
  localparam int Stages = Bits / 2;
  localparam int RemW   = Bits + 2;

  logic [67:0]     xs   [Stages+1];
  logic [RemW-1:0] rem  [Stages+1];
  logic [Bits-1:0] rt   [Stages+1];
  logic            vld  [Stages+1];
  logic [SideW-1:0] sd  [Stages+1];

  assign xs[0]  = {2'b00, x};
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign vld[0] = in_valid;
  assign sd[0]  = in_side;

  // Each stage resolves two root bits (one per half-step) in a narrow loop.
  for (genvar g = 0; g < Stages; g++) begin : g_stage
    logic [RemW-1:0] r_c;
    logic [Bits-1:0] q_c;
    logic [67:0]     x_c;
    logic [RemW-1:0] trial;
    always_comb begin
      r_c = rem[g];
      q_c = rt[g];
      x_c = xs[g];
      for (int k = 0; k < 2; k++) begin
        r_c   = {r_c[RemW-3:0], x_c[67:66]};
        x_c   = {x_c[65:0], 2'b00};
        trial = {q_c[Bits-3:0], 2'b01};
        if (r_c >= trial) begin
          r_c = r_c - trial;
          q_c = {q_c[Bits-2:0], 1'b1};
        end else begin
          q_c = {q_c[Bits-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
      if (en) begin
        rem[g+1] <= r_c;
        rt[g+1]  <= q_c;
        xs[g+1]  <= x_c;
        sd[g+1]  <= sd[g];
      end
    end
  end

  assign out_valid = vld[Stages];
  assign root      = rt[Stages][LenW-1:0];
  assign out_side  = sd[Stages];
endmodule

// ----- hw/rtl/bbpm_div.sv -----
// ----------------------------------------------------------------------------
// bbpm_div
// Pipelined signed divider, one quotient bit per stage, truncating to zero.
// ----------------------------------------------------------------------------
module bbpm_div #(
  parameter int SideW = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [bbpm_pkg::NumW-1:0]  num,
  input  logic [bbpm_pkg::LenW-1:0]         den,
  input  logic [SideW-1:0]                  in_side,
  output logic                              out_valid,
  output logic signed [bbpm_pkg::TrigW-1:0] quo,
  output logic [SideW-1:0]                  out_side
);
  import bbpm_pkg::*;

  // |num|/den <= 65536 always, so 17 quotient bits suffice.
  localparam int QB   = 17;
  localparam int MagW = NumW;
  localparam int RemW = LenW + 1;

  logic [MagW-1:0]  mag [QB+1];
  logic [RemW-1:0]  rem [QB+1];
  logic [QB-1:0]    q   [QB+1];
  logic             neg [QB+1];
  logic [LenW-1:0]  dn  [QB+1];
  logic             vld [QB+1];
  logic [SideW-1:0] sd  [QB+1];
  logic [MagW-1:0]  abs_num;

  assign abs_num = num[NumW-1] ? MagW'(-num) : MagW'(num);

  // Top bits of the magnitude above the quotient range seed the remainder.
  assign rem[0] = RemW'(abs_num >> QB);
  assign mag[0] = abs_num << (MagW - QB);
  assign q[0]   = '0;
  assign neg[0] = num[NumW-1];
  assign dn[0]  = den;
  assign vld[0] = in_valid;
  assign sd[0]  = in_side;

  for (genvar g = 0; g < QB; g++) begin : g_stage
    logic [RemW-1:0] sh;
    always_comb sh = {rem[g][RemW-2:0], mag[g][MagW-1]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
      if (en) begin
        if (sh >= {1'b0, dn[g]}) begin
          rem[g+1] <= sh - {1'b0, dn[g]};
          q[g+1]   <= {q[g][QB-2:0], 1'b1};
        end else begin
          rem[g+1] <= sh;
          q[g+1]   <= {q[g][QB-2:0], 1'b0};
        end
        mag[g+1] <= {mag[g][MagW-2:0], 1'b0};
        neg[g+1] <= neg[g];
        dn[g+1]  <= dn[g];
        sd[g+1]  <= sd[g];
      end
    end
  end

  assign out_valid = vld[QB];
  assign quo = neg[QB] ? -TrigW'({1'b0, q[QB]}) : TrigW'({1'b0, q[QB]});
  assign out_side = sd[QB];
endmodule

// ----- hw/rtl/bbpm_matrix.sv -----
// ----------------------------------------------------------------------------
// bbpm_matrix
// Binding store and matrix stages: bind matrix, pose product, saturation.
// ----------------------------------------------------------------------------
module bbpm_matrix #(
  parameter int BONE_COUNT = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic                              op,
  input  logic [4:0]                        bone,
  input  logic                              zero,
  input  logic signed [bbpm_pkg::CoordW-1:0] px,
  input  logic signed [bbpm_pkg::CoordW-1:0] py,
  input  logic signed [bbpm_pkg::TrigW-1:0]  c,
  input  logic signed [bbpm_pkg::TrigW-1:0]  s,
  output logic                              out_valid,
  output bbpm_pkg::mat_t                    mat,
  output logic                              out_zero
);
  import bbpm_pkg::*;

  localparam int IdxW = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;

  mat_t mem [BONE_COUNT];

  // Stage A: bind products, memory read.
  logic                a_v, a_op, a_zero, a_ok;
  logic signed [TrigW-1:0]  a_c, a_s;
  logic signed [CoordW-1:0] a_px, a_py;
  logic signed [41:0]  a_cpx, a_spy, a_spx, a_cpy;
  mat_t                a_b;
  logic                ok;
  logic [IdxW-1:0]     idx;

  always_comb begin
    ok  = ({4'b0000, bone} < 9'(BONE_COUNT));
    idx = IdxW'(bone);
  end

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (en) a_v <= in_valid;
    if (en) begin
      a_op <= op; a_zero <= zero; a_ok <= ok;
      a_c <= c; a_s <= s; a_px <= px; a_py <= py;
      a_cpx <= c * px; a_spy <= s * py; a_spx <= s * px; a_cpy <= c * py;
      a_b <= mem[idx];
    end
  end

  // Bind matrix in Q16.16 (floor, saturate).
  mat_t bm;
  always_comb begin
    bm.m00 = fsat(72'(a_c) <<< 8, 8);
    bm.m01 = fsat(-(72'(a_s) <<< 8), 8);
    bm.m02 = fsat(72'(a_spy) - 72'(a_cpx), 8);
    bm.m10 = fsat(72'(a_s) <<< 8, 8);
    bm.m11 = fsat(72'(a_c) <<< 8, 8);
    bm.m12 = fsat(-72'(a_spx) - 72'(a_cpy), 8);
  end

  // Stage B: store binding, forward on same-bone hazard with pipelined write.
  logic       b_v, b_op, b_zero, b_ok;
  logic signed [TrigW-1:0]  b_c, b_s;
  logic signed [CoordW-1:0] b_px, b_py;
  mat_t       b_bm, b_b;

  logic [4:0] a_bone, b_bone;
  always_ff @(posedge clk) if (en) a_bone <= bone;

  logic wr;
  assign wr = en && a_v && (a_op == OP_BIND) && !a_zero && a_ok;

  always_ff @(posedge clk) begin
    if (wr) mem[IdxW'(a_bone)] <= bm;
  end

  // A pose read in stage A may miss a bind in stage A/B just ahead of it.
  logic fwd_a;
  assign fwd_a = a_v && b_v && (b_op == OP_BIND) && !b_zero && b_ok && (b_bone == a_bone);

  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else if (en) b_v <= a_v;
    if (en) begin
      b_op <= a_op; b_zero <= a_zero; b_ok <= a_ok; b_bone <= a_bone;
      b_c <= a_c; b_s <= a_s; b_px <= a_px; b_py <= a_py;
      b_bm <= bm;
      b_b  <= fwd_a ? b_bm : a_b;
    end
  end

  mat_t bsel;
  always_comb bsel = b_ok ? b_b : '0;

  // Stage C: pose products.
  logic       c_v, c_op, c_zero;
  mat_t       c_bm;
  logic signed [CoordW-1:0] c_px, c_py;
  logic signed [49:0] p_cb00, p_sb10, p_cb01, p_sb11, p_cb02, p_sb12;
  logic signed [49:0] p_sb00, p_cb10, p_sb01, p_cb11, p_sb02, p_cb12;

  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else if (en) c_v <= b_v;
    if (en) begin
      c_op <= b_op; c_zero <= b_zero; c_bm <= b_bm; c_px <= b_px; c_py <= b_py;
      p_cb00 <= b_c * $signed(bsel.m00); p_sb10 <= b_s * $signed(bsel.m10);
      p_cb01 <= b_c * $signed(bsel.m01); p_sb11 <= b_s * $signed(bsel.m11);
      p_cb02 <= b_c * $signed(bsel.m02); p_sb12 <= b_s * $signed(bsel.m12);
      p_sb00 <= b_s * $signed(bsel.m00); p_cb10 <= b_c * $signed(bsel.m10);
      p_sb01 <= b_s * $signed(bsel.m01); p_cb11 <= b_c * $signed(bsel.m11);
      p_sb02 <= b_s * $signed(bsel.m02); p_cb12 <= b_c * $signed(bsel.m12);
    end
  end

  mat_t pm;
  always_comb begin
    pm.m00 = fsat(72'(p_cb00) + 72'(p_sb10), 16);
    pm.m01 = fsat(72'(p_cb01) + 72'(p_sb11), 16);
    pm.m02 = fsat(72'(p_cb02) + 72'(p_sb12) + (72'(c_px) <<< 24), 16);
    pm.m10 = fsat(72'(p_cb10) - 72'(p_sb00), 16);
    pm.m11 = fsat(72'(p_cb11) - 72'(p_sb01), 16);
    pm.m12 = fsat(72'(p_cb12) - 72'(p_sb02) + (72'(c_py) <<< 24), 16);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= c_v;
    if (en) begin
      out_zero <= c_zero;
      if (c_zero)
        mat <= '{m00: One, m01: '0, m02: '0, m10: '0, m11: One, m12: '0};
      else if (c_op == OP_BIND)
        mat <= c_bm;
      else
        mat <= pm;
    end
  end
endmodule

// ----- hw/rtl/bone_bind_and_pose_matrix_top.sv -----
// ----------------------------------------------------------------------------
// bone_bind_and_pose_matrix_top
// 2D bone bind / pose matrix pipeline for skeletal skinning.
// ----------------------------------------------------------------------------
// Input channel carries one bone item per transaction (operation, bone,
// start and end joint, Q16.8). Output channel returns one saturated Q16.16
// 2x3 matrix plus the zero_length flag per item, in order.
// The pipeline is a difference stage, 17 stages of square root (two root
// bits per stage), 17 divider stages (one quotient bit each), three matrix
// stages and the output register. The whole pipeline advances in lock step,
// so one item is taken per cycle while the receiver does not stall.
// When the receiver stalls, every stage holds; ready follows the output
// register's freedom, so nothing is lost or repeated.
// Reset clears all valid bits; the binding store keeps its contents and a
// pose on a bone never bound returns an undefined matrix.
// A pose that follows a bind of the same bone closely is served from the
// bind still in flight.
// ----------------------------------------------------------------------------
module bone_bind_and_pose_matrix_top #(
  parameter int BONE_COUNT = 32
) (
  input  logic      clk,
  input  logic      rst,
  bbpm_in_if.sink   in_ch,
  bbpm_out_if.source out_ch
);
  import bbpm_pkg::*;

  localparam int SideW = 1 + 5 + 1 + 2 * CoordW + 2 * DiffW;

  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 0: differences and squared length.
  logic                     d_v, d_op, d_zero;
  logic [4:0]               d_bone;
  logic signed [CoordW-1:0] d_px, d_py;
  logic signed [DiffW-1:0]  d_dx, d_dy;
  logic signed [DiffW-1:0]  dx, dy;
  assign dx = DiffW'(in_ch.end_x) - DiffW'(in_ch.start_x);
  assign dy = DiffW'(in_ch.end_y) - DiffW'(in_ch.start_y);

  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0;
    else if (en) d_v <= in_ch.valid;
    if (en) begin
      d_op <= in_ch.operation; d_bone <= in_ch.bone;
      d_px <= in_ch.start_x; d_py <= in_ch.start_y;
      d_dx <= dx; d_dy <= dy;
      d_zero <= (dx == '0) && (dy == '0);
    end
  end

  logic [SqW-1:0] l2;
  assign l2 = SqW'(50'(d_dx * d_dx)) + SqW'(50'(d_dy * d_dy));

  logic [SideW-1:0] sq_side, sq_side_o;
  assign sq_side = {d_op, d_bone, d_zero, d_px, d_py, d_dx, d_dy};
  logic             sq_v;
  logic [LenW-1:0]  lens;

  bbpm_sqrt #(.SideW(SideW)) u_sqrt (
    .clk, .rst, .en, .in_valid(d_v), .x({l2, 14'b0}), .in_side(sq_side),
    .out_valid(sq_v), .root(lens), .out_side(sq_side_o)
  );

  logic                     q_op, q_zero;
  logic [4:0]               q_bone;
  logic signed [CoordW-1:0] q_px, q_py;
  logic signed [DiffW-1:0]  q_dx, q_dy;
  assign {q_op, q_bone, q_zero, q_px, q_py, q_dx, q_dy} = sq_side_o;

  logic [LenW-1:0] den;
  assign den = q_zero ? LenW'(1) : lens;

  localparam int DSideW = 1 + 5 + 1 + 2 * CoordW;
  logic [DSideW-1:0] dc_side, ds_side;
  assign dc_side = {q_op, q_bone, q_zero, q_px, q_py};
  logic dc_v, ds_v;
  logic signed [TrigW-1:0] cq, sq;

  bbpm_div #(.SideW(DSideW)) u_div_c (
    .clk, .rst, .en, .in_valid(sq_v), .num(NumW'(q_dy) <<< 23), .den,
    .in_side(dc_side), .out_valid(dc_v), .quo(cq), .out_side(ds_side)
  );

  logic [DSideW-1:0] unused_side;
  bbpm_div #(.SideW(DSideW)) u_div_s (
    .clk, .rst, .en, .in_valid(sq_v), .num(NumW'(q_dx) <<< 23), .den,
    .in_side(dc_side), .out_valid(ds_v), .quo(sq), .out_side(unused_side)
  );

  logic                     m_op, m_zero;
  logic [4:0]               m_bone;
  logic signed [CoordW-1:0] m_px, m_py;
  assign {m_op, m_bone, m_zero, m_px, m_py} = ds_side;

  mat_t mat;
  logic o_zero, o_v;

  bbpm_matrix #(.BONE_COUNT(BONE_COUNT)) u_mat (
    .clk, .rst, .en, .in_valid(dc_v && ds_v && (unused_side == ds_side)),
    .op(m_op), .bone(m_bone), .zero(m_zero), .px(m_px), .py(m_py),
    .c(cq), .s(sq), .out_valid(o_v), .mat, .out_zero(o_zero)
  );

  assign out_ch.valid       = o_v;
  assign out_ch.m00         = mat.m00;
  assign out_ch.m01         = mat.m01;
  assign out_ch.m02         = mat.m02;
  assign out_ch.m10         = mat.m10;
  assign out_ch.m11         = mat.m11;
  assign out_ch.m12         = mat.m12;
  assign out_ch.zero_length = o_zero;
endmodule

// ----- hw/rtl/bbpm_checker.sv -----
// ----------------------------------------------------------------------------
// bbpm_port_checks
// Port-level checks on the bone matrix pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module bbpm_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        zero_length,
  input logic [31:0] m00,
  input logic [31:0] m11,
  input logic [31:0] m01
);
  import bbpm_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(m00) && $stable(m11))
    else $error("result changed under stall");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready not tied to output space");

  a_ident: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_length |-> m00 == One && m11 == One && m01 == '0)
    else $error("zero-length bone not identity");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");
endmodule

bind bone_bind_and_pose_matrix_top bbpm_port_checks u_checker (
  .clk, .rst, .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .zero_length(out_ch.zero_length),
  .m00(out_ch.m00), .m11(out_ch.m11), .m01(out_ch.m01)
);
